// File: rtl/core/tce_pkg.sv
// Shared types and constants for the toy CPU execute stage.
// Opcode encoding, stream word widths and byte-bank row helper; no dependencies.

package tce_pkg;

    localparam int DEF_MEM_BYTES = 1024;
    localparam int DEF_NUM_REGS  = 15;

    // stream word widths, padded to whole bytes
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 40;

    // byte memory is split in four banks by address bits [1:0]
    localparam int NUM_BANKS  = 4;
    localparam int BANK_ROW_W = 7;   // rows reachable from an 8-bit base plus three

    typedef enum logic [3:0] {
        OP_HALT  = 4'd0,
        OP_ADD   = 4'd1,
        OP_SUB   = 4'd2,
        OP_LOADI = 4'd3,
        OP_LOAD  = 4'd4,
        OP_MOVE  = 4'd5,
        OP_STORE = 4'd6,
        OP_JGT   = 4'd7,
        OP_JEQ   = 4'd8,
        OP_JNE   = 4'd9,
        OP_JMP   = 4'd10,
        OP_JNZ   = 4'd11,
        OP_JZ    = 4'd12,
        OP_JPOS  = 4'd13,
        OP_JNEG  = 4'd14,
        OP_UNDEF = 4'd15
    } op_t;

    typedef struct packed {
        logic        fwd;       // value comes from the write at the read edge
        logic [31:0] fwd_data;
        logic        valid;     // entry written since reset
    } rd_tag_t;

    // Row of bank k touched by the four-byte span starting at byte address base.
    function automatic logic [BANK_ROW_W-1:0] bank_row(input logic [7:0] base,
                                                       input logic [1:0] k);
        logic [1:0] off;
        logic [8:0] addr;
        off  = k - base[1:0];
        addr = {1'b0, base} + {7'b0, off};
        return addr[8:2];
    endfunction

endpackage

// File: rtl/core/tce_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// Read-first on a same-address write; no dependencies.

module tce_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/core/toy_cpu_execute_stage.sv
// Execute stage of a small register machine: register file plus byte memory.
// Depends on tce_pkg and tce_ram.

// One instruction enters per cycle unless m_tready holds the output. The
// register file (three copies, one read port each) and the four byte banks
// are read into the stage-1 registers, then the instruction executes, writes
// back and has its result word registered. A write that lands on the edge of
// a following read is forwarded, so back-to-back instructions see each other's
// results. Reset clears the byte memory one row per cycle with s_tready low.
// The register file needs no clearing pass: per-entry valid bits read as zero.

module toy_cpu_execute_stage #(
    parameter int MEM_BYTES = tce_pkg::DEF_MEM_BYTES,
    parameter int NUM_REGS  = tce_pkg::DEF_NUM_REGS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // mode[3:0], reg_a[7:4], operand_b[15:8], reg_c[19:16], immediate[51:20]
    input  logic [tce_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // program_counter[31:0], jump_taken[32], running[33],
    // undefined_opcode[34], bad_register[35]
    output logic [tce_pkg::M_TDATA_W-1:0]  m_tdata
);

    localparam int REG_AW    = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam int BANK_ROWS = (MEM_BYTES + 3) / 4;
    localparam int BANK_AW   = $clog2(BANK_ROWS);
    localparam int NB        = tce_pkg::NUM_BANKS;

    // ---------------- input unpack ----------------
    tce_pkg::op_t s_mode;
    logic [3:0]   s_reg_a;
    logic [7:0]   s_operand_b;
    logic [3:0]   s_reg_c;
    logic [31:0]  s_immediate;

    assign s_mode      = tce_pkg::op_t'(s_tdata[3:0]);
    assign s_reg_a     = s_tdata[7:4];
    assign s_operand_b = s_tdata[15:8];
    assign s_reg_c     = s_tdata[19:16];
    assign s_immediate = s_tdata[51:20];

    // ---------------- control registers ----------------
    logic                  clr_active_reg;
    logic [BANK_AW-1:0]    clr_row_reg;
    logic                  s1_valid_reg;
    logic                  m_valid_reg;
    logic                  running_reg;
    logic [31:0]           pc_reg;
    logic [NUM_REGS-1:0]   reg_valid_reg;

    // stage-1 payload
    tce_pkg::op_t          s1_op_reg;
    logic [3:0]            s1_a_reg;
    logic [7:0]            s1_b_reg;
    logic [3:0]            s1_c_reg;
    logic [31:0]           s1_imm_reg;
    tce_pkg::rd_tag_t      s1_tag_reg [3];
    logic [NB-1:0]         s1_mfwd_reg;
    logic [7:0]            s1_mfwd_data_reg [NB];

    // output word
    logic [31:0]           m_pc_reg;
    logic                  m_taken_reg;
    logic                  m_running_reg;
    logic                  m_undef_reg;
    logic                  m_bad_reg;

    logic s_accept;
    logic s1_adv;

    assign s1_adv   = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !clr_active_reg && (!s1_valid_reg || s1_adv);
    assign s_accept = s_tvalid && s_tready;

    // ---------------- register file (three read copies) ----------------
    logic              rf_we;
    logic [REG_AW-1:0] rf_waddr;
    logic [31:0]       rf_wdata;
    logic [REG_AW-1:0] rf_raddr [3];
    logic [31:0]       rf_rdata [3];
    logic [2:0]        rd_ok;

    assign rf_raddr[0] = s_reg_a[REG_AW-1:0];
    assign rf_raddr[1] = s_operand_b[REG_AW-1:0];
    assign rf_raddr[2] = s_reg_c[REG_AW-1:0];
    assign rd_ok[0]    = {1'b0, s_reg_a} < 5'(NUM_REGS);
    assign rd_ok[1]    = s_operand_b < 8'(NUM_REGS);
    assign rd_ok[2]    = {1'b0, s_reg_c} < 5'(NUM_REGS);

    for (genvar p = 0; p < 3; p++) begin : g_rf
        tce_ram #(
            .WIDTH (32),
            .DEPTH (NUM_REGS)
        ) u_rf (
            .clk   (aclk),
            .we    (rf_we),
            .waddr (rf_waddr),
            .wdata (rf_wdata),
            .re    (s_accept),
            .raddr (rf_raddr[p]),
            .rdata (rf_rdata[p])
        );
    end

    // ---------------- byte memory (four banks by address[1:0]) ----------------
    logic                bank_we;
    logic [BANK_AW-1:0]  bank_waddr [NB];
    logic [7:0]          bank_wdata [NB];
    logic [BANK_AW-1:0]  bank_raddr [NB];
    logic [7:0]          bank_rdata [NB];
    logic                mem_wr;
    logic [7:0]          st_byte [NB];

    for (genvar k = 0; k < NB; k++) begin : g_bank
        assign bank_raddr[k] = BANK_AW'(tce_pkg::bank_row(s_operand_b, 2'(k)));
        assign bank_waddr[k] = clr_active_reg ? clr_row_reg
                             : BANK_AW'(tce_pkg::bank_row(s1_b_reg, 2'(k)));
        assign bank_wdata[k] = clr_active_reg ? 8'h00 : st_byte[k];

        tce_ram #(
            .WIDTH (8),
            .DEPTH (BANK_ROWS)
        ) u_bank (
            .clk   (aclk),
            .we    (bank_we),
            .waddr (bank_waddr[k]),
            .wdata (bank_wdata[k]),
            .re    (s_accept),
            .raddr (bank_raddr[k]),
            .rdata (bank_rdata[k])
        );
    end

    assign bank_we = clr_active_reg || mem_wr;

    // ---------------- execute ----------------
    logic [31:0] va, vb, vc;
    logic [7:0]  mbyte [NB];
    logic [31:0] load_word;
    logic        use_a, use_b, use_c;
    logic        bad, undef, commit, is_jump, cond, taken;
    logic        reg_wr;
    logic [3:0]  wr_idx;
    logic [31:0] wr_val;
    logic        halt_now;

    always_comb begin
        logic [1:0] bsel;
        logic [1:0] j2;
        va = s1_tag_reg[0].fwd ? s1_tag_reg[0].fwd_data
           : (s1_tag_reg[0].valid ? rf_rdata[0] : 32'd0);
        vb = s1_tag_reg[1].fwd ? s1_tag_reg[1].fwd_data
           : (s1_tag_reg[1].valid ? rf_rdata[1] : 32'd0);
        vc = s1_tag_reg[2].fwd ? s1_tag_reg[2].fwd_data
           : (s1_tag_reg[2].valid ? rf_rdata[2] : 32'd0);

        for (int k = 0; k < NB; k++) begin
            mbyte[k] = s1_mfwd_reg[k] ? s1_mfwd_data_reg[k] : bank_rdata[k];
        end
        // little-endian assembly on load
        for (int j = 0; j < 4; j++) begin
            bsel = s1_b_reg[1:0] + 2'(j);
            load_word[8*j +: 8] = mbyte[bsel];
        end
        // big-endian placement on store: byte j of the span gets va[31-8j -: 8]
        for (int k = 0; k < NB; k++) begin
            j2 = 2'(k) - s1_b_reg[1:0];
            st_byte[k] = va[8*(3-j2) +: 8];
        end
    end

    always_comb begin
        use_a   = 1'b0;
        use_b   = 1'b0;
        use_c   = 1'b0;
        is_jump = 1'b0;
        cond    = 1'b0;
        unique case (s1_op_reg) inside
            tce_pkg::OP_ADD, tce_pkg::OP_SUB: begin
                use_a = 1'b1; use_b = 1'b1; use_c = 1'b1;
            end
            tce_pkg::OP_JGT, tce_pkg::OP_JEQ, tce_pkg::OP_JNE: begin
                use_a = 1'b1; use_b = 1'b1; use_c = 1'b1; is_jump = 1'b1;
            end
            tce_pkg::OP_MOVE: begin
                use_a = 1'b1; use_b = 1'b1;
            end
            tce_pkg::OP_JNZ, tce_pkg::OP_JZ, tce_pkg::OP_JPOS, tce_pkg::OP_JNEG: begin
                use_a = 1'b1; use_b = 1'b1; is_jump = 1'b1;
            end
            tce_pkg::OP_LOADI, tce_pkg::OP_LOAD, tce_pkg::OP_STORE: begin
                use_a = 1'b1;
            end
            tce_pkg::OP_JMP: begin
                use_a = 1'b1; is_jump = 1'b1;
            end
            default: begin
            end
        endcase

        case (s1_op_reg)
            tce_pkg::OP_JGT:  cond = $signed(vb) > $signed(vc);
            tce_pkg::OP_JEQ:  cond = vb == vc;
            tce_pkg::OP_JNE:  cond = vb != vc;
            tce_pkg::OP_JMP:  cond = 1'b1;
            tce_pkg::OP_JNZ:  cond = vb != 32'd0;
            tce_pkg::OP_JZ:   cond = vb == 32'd0;
            tce_pkg::OP_JPOS: cond = $signed(vb) > 32'sd0;
            tce_pkg::OP_JNEG: cond = vb[31];
            default:          cond = 1'b0;
        endcase
    end

    assign bad = (use_a && !({1'b0, s1_a_reg} < 5'(NUM_REGS)))
              || (use_b && !(s1_b_reg < 8'(NUM_REGS)))
              || (use_c && !({1'b0, s1_c_reg} < 5'(NUM_REGS)));
    assign undef    = s1_op_reg == tce_pkg::OP_UNDEF;
    assign commit   = !undef && !bad;
    assign taken    = commit && is_jump && cond;
    assign halt_now = commit && s1_op_reg == tce_pkg::OP_HALT;
    assign mem_wr   = s1_adv && commit && s1_op_reg == tce_pkg::OP_STORE;

    always_comb begin
        reg_wr = 1'b0;
        wr_idx = 4'd0;
        wr_val = va;
        case (s1_op_reg)
            tce_pkg::OP_ADD: begin
                reg_wr = 1'b1; wr_idx = s1_c_reg; wr_val = va + vb;
            end
            tce_pkg::OP_SUB: begin
                reg_wr = 1'b1; wr_idx = s1_c_reg; wr_val = va - vb;
            end
            tce_pkg::OP_LOADI: begin
                reg_wr = 1'b1; wr_idx = s1_a_reg; wr_val = s1_imm_reg;
            end
            tce_pkg::OP_LOAD: begin
                reg_wr = 1'b1; wr_idx = s1_a_reg; wr_val = load_word;
            end
            tce_pkg::OP_MOVE: begin
                reg_wr = 1'b1; wr_idx = s1_b_reg[3:0]; wr_val = va;
            end
            default: begin
                // taken jump copies reg_a into the program counter
                reg_wr = taken; wr_idx = 4'd0; wr_val = va;
            end
        endcase
    end

    assign rf_we    = s1_adv && commit && reg_wr;
    assign rf_waddr = wr_idx[REG_AW-1:0];
    assign rf_wdata = wr_val;

    // ---------------- forwarding for a read on a write edge ----------------
    tce_pkg::rd_tag_t tag_next [3];
    logic [NB-1:0]    mfwd_next;

    always_comb begin
        for (int p = 0; p < 3; p++) begin
            tag_next[p].fwd      = rf_we && rf_waddr == rf_raddr[p];
            tag_next[p].fwd_data = rf_wdata;
            tag_next[p].valid    = rd_ok[p] && reg_valid_reg[rf_raddr[p]];
        end
        for (int k = 0; k < NB; k++) begin
            mfwd_next[k] = mem_wr && bank_raddr[k] == bank_waddr[k];
        end
    end

    // ---------------- next values ----------------
    logic [31:0] pc_next;
    logic        running_next;
    logic        m_valid_next;

    assign pc_next      = (rf_we && rf_waddr == '0) ? rf_wdata : pc_reg;
    assign running_next = (s1_adv && halt_now) ? 1'b0 : running_reg;
    assign m_valid_next = s1_adv || (m_valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_active_reg <= 1'b1;
            clr_row_reg    <= '0;
            s1_valid_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
            running_reg    <= 1'b1;
            pc_reg         <= 32'd0;
            reg_valid_reg  <= '0;
        end else begin
            if (clr_active_reg) begin
                clr_row_reg <= clr_row_reg + 1'b1;
                if (clr_row_reg == BANK_AW'(BANK_ROWS - 1)) begin
                    clr_active_reg <= 1'b0;
                end
            end
            if (s_accept) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_adv) begin
                s1_valid_reg <= 1'b0;
            end
            m_valid_reg <= m_valid_next;
            running_reg <= running_next;
            pc_reg      <= pc_next;
            if (rf_we) begin
                reg_valid_reg[rf_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_op_reg   <= s_mode;
            s1_a_reg    <= s_reg_a;
            s1_b_reg    <= s_operand_b;
            s1_c_reg    <= s_reg_c;
            s1_imm_reg  <= s_immediate;
            s1_mfwd_reg <= mfwd_next;
            for (int p = 0; p < 3; p++) begin
                s1_tag_reg[p] <= tag_next[p];
            end
            for (int k = 0; k < NB; k++) begin
                s1_mfwd_data_reg[k] <= bank_wdata[k];
            end
        end
        if (s1_adv) begin
            m_pc_reg      <= pc_next;
            m_taken_reg   <= taken;
            m_running_reg <= running_next;
            m_undef_reg   <= undef;
            m_bad_reg     <= bad;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'd0, m_bad_reg, m_undef_reg, m_running_reg, m_taken_reg, m_pc_reg};

endmodule
